// ----- rtl/core/rtcm_pkg.sv -----
// Shared types and constants for the range table character mapper.
// No dependencies; imported by the interfaces, the core and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rtcm_pkg;

   localparam int unsigned MAX_RANGES_DEF = 256;

   localparam int unsigned CODE_W  = 32;
   localparam int unsigned BOUND_W = 31;
   localparam int unsigned SLOT_W  = 8;
   localparam int unsigned COUNT_W = 9;
   // search cursor: one bit above the count so base + half never wraps
   localparam int unsigned CUR_W   = COUNT_W + 1;

   localparam logic              KIND_LOAD  = 1'b0;
   localparam logic              KIND_XLATE = 1'b1;
   localparam logic [CODE_W-1:0] EOF_CODE   = '1;

   typedef struct packed {
      logic [BOUND_W-1:0] lo;
      logic [BOUND_W-1:0] hi;
      logic [BOUND_W-1:0] map;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/rtcm_if.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on rtcm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rtcm_req_if import rtcm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [SLOT_W-1:0]  entry_index;
   logic [BOUND_W-1:0] range_min;
   logic [BOUND_W-1:0] range_max;
   logic [BOUND_W-1:0] range_map;
   logic [CODE_W-1:0]  char_in;

   modport source (output valid, kind, entry_index, range_min, range_max, range_map,
                   char_in, input ready);
   modport sink   (input valid, kind, entry_index, range_min, range_max, range_map,
                   char_in, output ready);
endinterface

interface rtcm_rsp_if import rtcm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] char_out;
   logic              hit;

   modport source (output valid, char_out, hit, input ready);
   modport sink   (input valid, char_out, hit, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/range_table_char_mapper.sv -----
// Range table character mapper: table memory, binary search sequencer, output register.
// Depends on rtcm_pkg and the channel interfaces in rtcm_if.sv.
//
// Usage:
//  req_chan carries items. kind = load writes entry_index with range_min/max/map
//  (slots at or above MAX_RANGES are dropped) and gives no response. kind = translate
//  searches the first csr range entries (saturated to MAX_RANGES) and returns one
//  response on rsp_chan: char_out and hit.
//  csr_we/csr_wdata write the range count; write it only while the block is idle.
//  Steps: a load is written as it is accepted. A translate has an accept step, then
//  probes of the table memory's registered read port (floor(log2(count)) + 1 at most, 9 for
//  256 entries, fewer on an early hit, none for end of file or an empty table)
//  and a final step that loads the output register. Each probe is a registered
//  memory read, a compare and the next address.
//  req_chan.ready is low while a translate is in flight. If rsp_chan stalls, the
//  finished item waits in the sequencer until the output register frees.
//  Reset clears the sequencer, the output valid and the range count; table
//  contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module range_table_char_mapper import rtcm_pkg::*; #(
   parameter int unsigned MAX_RANGES = MAX_RANGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [COUNT_W-1:0] csr_wdata,
   rtcm_req_if.sink                req_chan,
   rtcm_rsp_if.source              rsp_chan
);

   localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

   entry_type mem [MAX_RANGES];
   entry_type rd_ff;
   logic [AW-1:0] rd_addr;

   state_type         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [CUR_W-1:0]  base_ff, base_in, x_ff, x_in, probe_ff, probe_in;
   logic [CODE_W-1:0] code_ff, code_in, result_ff, result_in;
   logic              hit_ff, hit_in;
   logic [CODE_W-1:0] char_out_ff;
   logic              hit_out_ff, rsp_valid_ff;
   logic              out_load;

   logic              accept, write_en;
   logic [CUR_W-1:0]  cnt_sat;
   logic [CUR_W-1:0]  nb, nx, np;
   logic              go;
   logic              lo_le, hi_ge, ge_hi;
   logic [CODE_W-1:0] mapped;

   assign accept   = req_chan.valid && req_chan.ready;
   assign write_en = accept && (req_chan.kind == KIND_LOAD) &&
                     (32'(req_chan.entry_index) < 32'(MAX_RANGES));
   assign cnt_sat  = (32'(count_ff) > 32'(MAX_RANGES)) ? CUR_W'(MAX_RANGES)
                                                       : CUR_W'(count_ff);

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[AW'(req_chan.entry_index)] <= '{lo:  req_chan.range_min,
                                             hi:  req_chan.range_max,
                                             map: req_chan.range_map};
      end
      rd_ff <= mem[rd_addr];
   end

   assign lo_le  = $signed({1'b0, rd_ff.lo}) <= $signed(code_ff);
   assign hi_ge  = $signed({1'b0, rd_ff.hi}) >= $signed(code_ff);
   assign ge_hi  = $signed(code_ff) >= $signed({1'b0, rd_ff.hi});
   assign mapped = {1'b0, rd_ff.map} + code_ff - {1'b0, rd_ff.lo};

   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      x_in      = x_ff;
      probe_in  = probe_ff;
      code_in   = code_ff;
      result_in = result_ff;
      hit_in    = hit_ff;
      out_load  = 1'b0;
      nb        = base_ff;
      nx        = x_ff;
      case (state_ff)
         ST_IDLE: begin
            nb = '0;
            nx = cnt_sat;
         end
         ST_SEARCH: begin
            if (ge_hi) begin
               nb = probe_ff + CUR_W'(1);
               nx = (x_ff - CUR_W'(1)) >> 1;
            end else begin
               nb = base_ff;
               nx = x_ff >> 1;
            end
         end
         default: begin
            nb = base_ff;
            nx = x_ff;
         end
      endcase
      np      = nb + (nx >> 1);
      go      = (nx != '0) && (32'(np) < 32'(MAX_RANGES));
      rd_addr = AW'(np);

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_chan.kind == KIND_XLATE) begin
               code_in   = req_chan.char_in;
               result_in = req_chan.char_in;
               hit_in    = 1'b0;
               base_in   = nb;
               x_in      = nx;
               probe_in  = np;
               if (go && req_chan.char_in != EOF_CODE) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SEARCH: begin
            if (lo_le && hi_ge) begin
               result_in = mapped;
               hit_in    = 1'b1;
               state_in  = ST_DONE;
            end else begin
               base_in  = nb;
               x_in     = nx;
               probe_in = np;
               if (!go) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      x_ff      <= x_in;
      probe_ff  <= probe_in;
      code_ff   <= code_in;
      result_ff <= result_in;
      hit_ff    <= hit_in;
      if (out_load) begin
         char_out_ff <= result_ff;
         hit_out_ff  <= hit_ff;
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.char_out = char_out_ff;
   assign rsp_chan.hit      = hit_out_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rtcm_checker.sv -----
// Port-level checks for range_table_char_mapper, attached by bind.
// Depends on rtcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtcm_checker import rtcm_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              req_kind,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CODE_W-1:0] rsp_char_out,
   input wire logic              rsp_hit
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   a_busy_after_xlate: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_XLATE) |=> !req_ready)
      else $error("translate item did not hold the block busy");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without a translate in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_char_out) && $stable(rsp_hit))
      else $error("stalled response changed");

endmodule

bind range_table_char_mapper rtcm_checker u_rtcm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_kind     (req_chan.kind),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_char_out (rsp_chan.char_out),
   .rsp_hit      (rsp_chan.hit)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for range_table_char_mapper: loads range tables, sets the range count and
// checks each translated code and hit flag against a built-in binary search predictor.
// Depends on rtcm_pkg and the channel interfaces in rtcm_if.sv.
`timescale 1ns / 1ps

module testbench;
   import rtcm_pkg::*;

   localparam int unsigned DEPTH = MAX_RANGES_DEF;

   typedef struct packed {
      logic [CODE_W-1:0] char_out;
      logic              hit;
   } map_result_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_we;
   logic [COUNT_W-1:0] csr_wdata;

   rtcm_req_if req_bus ();
   rtcm_rsp_if rsp_bus ();

   range_table_char_mapper #(.MAX_RANGES(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // predictor state
   entry_type          map_table [DEPTH];
   bit                 slot_loaded [DEPTH];
   logic [COUNT_W-1:0] live_count;
   map_result_type     pending_maps [$];

   entry_type      stage_tab [DEPTH];
   map_result_type oldest_map;
   int unsigned    fail_count = 0;
   int unsigned    sent_count = 0;
   int unsigned    src_idle_pct;
   int unsigned    sink_idle_pct;

   always #2 clock = ~clock;

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_maps.size() == 0) begin
            $error("unexpected item: char_out %h hit %b", rsp_bus.char_out, rsp_bus.hit);
            fail_count++;
         end else begin
            oldest_map = pending_maps.pop_front();
            if (rsp_bus.char_out !== oldest_map.char_out) begin
               $error("char_out mismatch: expected %h, actual %h",
                      oldest_map.char_out, rsp_bus.char_out);
               fail_count++;
            end
            if (rsp_bus.hit !== oldest_map.hit) begin
               $error("hit mismatch: expected %b, actual %b", oldest_map.hit, rsp_bus.hit);
               fail_count++;
            end
         end
      end
   end

   function automatic void predict_mapping(logic kind, logic [SLOT_W-1:0] slot, entry_type e,
                                           logic [CODE_W-1:0] code);
      map_result_type r;
      int unsigned cnt, base, x, probe;
      longint      sval, lo, hi;
      if (kind == KIND_LOAD) begin
         if (slot < DEPTH) begin
            map_table[slot]   = e;
            slot_loaded[slot] = 1'b1;
         end
         return;
      end
      r.char_out = code;
      r.hit      = 1'b0;
      if (code != EOF_CODE) begin
         cnt  = (live_count > DEPTH) ? DEPTH : live_count;
         sval = $signed(code);
         base = 0;
         for (x = cnt; x != 0; x = x >> 1) begin
            probe = base + (x >> 1);
            if (probe >= DEPTH) break;
            lo = map_table[probe].lo;
            hi = map_table[probe].hi;
            if (lo <= sval && hi >= sval) begin
               r.char_out = {1'b0, map_table[probe].map} + code - {1'b0, map_table[probe].lo};
               r.hit      = 1'b1;
               break;
            end else if (sval >= hi) begin
               base = probe + 1;
               x--;
            end
         end
      end
      pending_maps.push_back(r);
   endfunction

   task automatic send_req(input logic kind, input logic [SLOT_W-1:0] slot, input entry_type e,
                           input logic [CODE_W-1:0] code);
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.entry_index <= slot;
      req_bus.range_min   <= e.lo;
      req_bus.range_max   <= e.hi;
      req_bus.range_map   <= e.map;
      req_bus.char_in     <= code;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_mapping(kind, slot, e, code);
      sent_count++;
   endtask

   function automatic entry_type mk_entry(logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi,
                                          logic [BOUND_W-1:0] map);
      entry_type e;
      e.lo  = lo;
      e.hi  = hi;
      e.map = map;
      return e;
   endfunction

   function automatic entry_type rand_entry();
      return mk_entry(31'($urandom), 31'($urandom), 31'($urandom));
   endfunction

   task automatic load_slot(input logic [SLOT_W-1:0] slot, input entry_type e);
      send_req(KIND_LOAD, slot, e, $urandom);
   endtask

   task automatic translate(input logic [CODE_W-1:0] code);
      send_req(KIND_XLATE, 8'($urandom), rand_entry(), code);
   endtask

   // drop valid, drain all results, then cover the tail of a load still in flight
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_range_count(input logic [COUNT_W-1:0] value);
      settle_block();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we     <= 1'b0;
      live_count  = value;
   endtask

   function automatic int unsigned loaded_prefix();
      int unsigned i;
      for (i = 0; i < DEPTH; i++) begin
         if (!slot_loaded[i]) return i;
      end
      return DEPTH;
   endfunction

   function automatic logic [COUNT_W-1:0] legal_count();
      int unsigned top;
      top = loaded_prefix();
      if (top == DEPTH) return COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
      return COUNT_W'($urandom_range(0, top));
   endfunction

   // codes aimed at bounds, interiors and neighbors of live entries, plus EOF and noise
   function automatic logic [CODE_W-1:0] pick_code();
      int unsigned       live, r;
      entry_type         e;
      longint unsigned   span;
      live = (live_count > DEPTH) ? DEPTH : live_count;
      r    = $urandom_range(0, 99);
      if (r < 8) return EOF_CODE;
      if (r < 16) return {1'b1, 31'($urandom)};
      if (r < 30 || live == 0) return {1'b0, 31'($urandom)};
      e = map_table[$urandom_range(0, live - 1)];
      r = $urandom_range(0, 9);
      if (r == 0) return {1'b0, e.lo};
      if (r == 1) return {1'b0, e.hi};
      if (r == 2) return {1'b0, e.lo - 31'd1};
      if (r == 3) return {1'b0, e.hi + 31'd1};
      if (e.hi < e.lo) return {1'b0, e.lo};
      span = e.hi - e.lo;
      span = span + 1;
      return {1'b0, 31'(e.lo + ($urandom % span))};
   endfunction

   function automatic void fill_sorted(int unsigned n, bit dense);
      longint unsigned per, origin, lo, hi;
      int unsigned     i;
      if (dense) begin
         per = $urandom_range(4, 96);
         if ($urandom_range(0, 1)) origin = $urandom_range(0, 128);
         else origin = $urandom % (64'h8000_0000 - n * per);
      end else begin
         per    = 64'h8000_0000 / n;
         origin = 0;
      end
      for (i = 0; i < n; i++) begin
         lo = origin + i * per + ($urandom % (per / 2));
         hi = lo + ($urandom % (per / 2));
         stage_tab[i].lo = 31'(lo);
         stage_tab[i].hi = 31'(hi);
         case ($urandom_range(0, 2))
            0: stage_tab[i].map = 31'(lo + 32);
            1: stage_tab[i].map = 31'(lo - 32);
            default: stage_tab[i].map = 31'($urandom);
         endcase
      end
   endfunction

   function automatic void fill_scrambled(int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++) begin
         stage_tab[i] = rand_entry();
         if ($urandom_range(0, 1)) begin
            stage_tab[i].hi = stage_tab[i].lo + 31'($urandom_range(0, 1000));
         end
      end
   endfunction

   task automatic load_staged(input int unsigned n);
      int unsigned       i, rot, slot;
      bit                rev;
      rot = $urandom_range(0, n - 1);
      rev = $urandom_range(0, 1);
      for (i = 0; i < n; i++) begin
         slot = ((rev ? n - 1 - i : i) + rot) % n;
         load_slot(8'(slot), stage_tab[slot]);
      end
   endtask

   task automatic test_directed_cases();
      load_slot(8'd0, mk_entry(31'd0, 31'd0, 31'h7FFF_FFFF));
      load_slot(8'd1, mk_entry(31'h41, 31'h5A, 31'h61));
      load_slot(8'd2, mk_entry(31'h100, 31'h1FF, 31'd0));
      load_slot(8'd3, mk_entry(31'h7FFF_FFFE, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
      set_range_count(9'd4);
      translate(32'd0);
      translate(32'h41);
      translate(32'h5A);
      translate(32'h4D);
      translate(32'h40);
      translate(32'h150);
      translate(32'h200);
      translate(32'h7FFF_FFFE);
      translate(32'h7FFF_FFFF);   // wraps past the sign bit
      translate(EOF_CODE);
      translate(32'h8000_0000);
      translate(32'hFFFF_FFFE);
      set_range_count(9'd0);      // empty table
      translate(32'h41);
      translate(EOF_CODE);
   endtask

   task automatic test_full_table();
      int unsigned i;
      fill_sorted(DEPTH, $urandom_range(0, 1));
      load_staged(DEPTH);
      set_range_count(9'(DEPTH));
      for (i = 0; i < 60; i++) translate(pick_code());
   endtask

   task automatic test_count_saturation();
      int unsigned i;
      set_range_count(9'd511);
      for (i = 0; i < 20; i++) translate(pick_code());
      set_range_count(9'(257 + $urandom_range(0, 253)));
      for (i = 0; i < 20; i++) translate(pick_code());
      set_range_count(9'd1);
      for (i = 0; i < 10; i++) translate(pick_code());
   endtask

   task automatic test_random_tables(input int unsigned target);
      int unsigned        first, n, k, j;
      logic [COUNT_W-1:0] cnt;
      first = sent_count;
      while (sent_count - first < target) begin
         n = ($urandom_range(0, 19) == 0) ? DEPTH : $urandom_range(1, 12);
         if ($urandom_range(0, 3) == 0) fill_scrambled(n);
         else fill_sorted(n, $urandom_range(0, 1));
         load_staged(n);
         cnt = COUNT_W'(n);
         if ($urandom_range(0, 5) == 0) cnt = legal_count();
         set_range_count(cnt);
         k = $urandom_range(6, 24);
         for (j = 0; j < k; j++) begin
            if ($urandom_range(0, 19) == 0) load_slot(8'($urandom), rand_entry());
            else translate(pick_code());
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      live_count          = '0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_LOAD;
      req_bus.entry_index = '0;
      req_bus.range_min   = '0;
      req_bus.range_max   = '0;
      req_bus.range_map   = '0;
      req_bus.char_in     = '0;
      rsp_bus.ready       = 1'b0;
      src_idle_pct        = 13;
      sink_idle_pct       = 65;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_table();
      test_count_saturation();
      test_random_tables(240);

      src_idle_pct  = 65;
      sink_idle_pct = 13;
      test_random_tables(240);

      src_idle_pct  = 0;
      sink_idle_pct = 0;
      test_random_tables(240);

      settle_block();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
